>>> sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the binary to decimal converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define B2AD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is low.
`define B2AD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define B2AD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define B2AD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/b2ad_pkg.sv
// Types and constants of the binary to decimal converter.
`default_nettype none
package b2ad_pkg;
  localparam int VALUE_W         = 32;
  localparam int NUM_DIGITS      = 10;
  localparam int BCD_W           = 4 * NUM_DIGITS;
  localparam int STEPS_PER_STAGE = 8;
  localparam int NUM_STAGES      = VALUE_W / STEPS_PER_STAGE;
  localparam int IDX_W           = 4;
  localparam int COUNT_W         = 4;
  localparam int CHAR_W          = 6;
  localparam int OUT_DATA_W      = 16;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // Double dabble working word: BCD digits on top, remaining binary below.
  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] bin;
  } dab_t;
endpackage
`default_nettype wire

>>> sv/binary_to_ascii_decimal.sv
// Top level: 32-bit binary to ASCII decimal converter.
//
//  channel | direction | tdata (low bit up)                      | tlast
//  in_     | input     | value[31:0]                             | -
//  out_    | output    | digit_char[5:0], digit_count[9:6], zero | last_digit
//
// A word passes four double dabble stages, eight shift steps each, then the
// serializer sends one digit per cycle while out_tready is high. It takes a new
// word in the same cycle that the last digit of the old word is sent.
// Synchronous active-low reset clears the valid bits only. Either side may
// stall at any time; no word is lost.
`default_nettype none
`include "assert_macros.svh"
module binary_to_ascii_decimal (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // value[31:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // digit_char[5:0], digit_count[9:6], zero fill
  output logic             out_tlast
);
  b2ad_pkg::dab_t stg_data  [0:b2ad_pkg::NUM_STAGES];
  logic           stg_valid [0:b2ad_pkg::NUM_STAGES];
  logic           stg_ready [0:b2ad_pkg::NUM_STAGES];

  logic [b2ad_pkg::CHAR_W-1:0]  digit_char;
  logic [b2ad_pkg::COUNT_W-1:0] digit_count;

  // Pipeline entry
  assign stg_data[0].bcd = '0;
  assign stg_data[0].bin = in_tdata;
  assign stg_valid[0]    = in_tvalid;
  assign in_tready       = stg_ready[0];

  // Double dabble stages
  for (genvar g = 0; g < b2ad_pkg::NUM_STAGES; g++) begin : g_stage
    b2ad_dabble_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[g]),
      .up_ready (stg_ready[g]),
      .up_data  (stg_data[g]),
      .dn_valid (stg_valid[g+1]),
      .dn_ready (stg_ready[g+1]),
      .dn_data  (stg_data[g+1])
    );
  end

  // Digit serializer
  b2ad_emitter u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (stg_valid[b2ad_pkg::NUM_STAGES]),
    .up_ready  (stg_ready[b2ad_pkg::NUM_STAGES]),
    .up_bcd    (stg_data[b2ad_pkg::NUM_STAGES].bcd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (digit_char),
    .out_last  (out_tlast),
    .out_count (digit_count)
  );

  assign out_tdata = {6'b0, digit_count, digit_char};

  // Checks
  `B2AD_ASSERT_IMPLY(a_char_range, clk, rst_n, out_tvalid,
    out_tdata[5:0] >= 6'd48 && out_tdata[5:0] <= 6'd57)
  `B2AD_ASSERT_IMPLY(a_count_range, clk, rst_n, out_tvalid,
    out_tdata[9:6] >= 4'd1 && out_tdata[9:6] <= 4'd10)
  `B2AD_ASSERT_NEXT(a_run_no_gap, clk, rst_n, out_tvalid && out_tready && !out_tlast,
    out_tvalid && out_tdata[9:6] == $past(out_tdata[9:6]))
  `B2AD_ASSERT_IMPLY(a_single_zero, clk, rst_n,
    out_tvalid && out_tdata[9:6] == 4'd1, out_tlast)
endmodule
`default_nettype wire

>>> sv/b2ad_dabble_stage.sv
// One pipeline stage of the double dabble: eight add-3 and shift steps.
`default_nettype none
module b2ad_dabble_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  wire b2ad_pkg::dab_t up_data,
  output logic               dn_valid,
  input  wire logic          dn_ready,
  output b2ad_pkg::dab_t     dn_data
);
  logic           valid_r;
  b2ad_pkg::dab_t data_r;
  b2ad_pkg::dab_t data_nxt;

  // Stage accepts when empty or when its word moves on
  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  // Eight steps: adjust each digit of five or more, then shift left
  always_comb begin
    logic [b2ad_pkg::BCD_W+b2ad_pkg::VALUE_W-1:0] w;
    logic [3:0] d;
    w = {up_data.bcd, up_data.bin};
    for (int s = 0; s < b2ad_pkg::STEPS_PER_STAGE; s++) begin
      for (int k = 0; k < b2ad_pkg::NUM_DIGITS; k++) begin
        d = w[b2ad_pkg::VALUE_W + 4*k +: 4];
        if (d >= 4'd5) begin
          w[b2ad_pkg::VALUE_W + 4*k +: 4] = d + 4'd3;
        end
      end
      w = w << 1;
    end
    data_nxt.bcd = w[b2ad_pkg::BCD_W+b2ad_pkg::VALUE_W-1:b2ad_pkg::VALUE_W];
    data_nxt.bin = w[b2ad_pkg::VALUE_W-1:0];
  end

  // Valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end
endmodule
`default_nettype wire

>>> sv/b2ad_emitter.sv
// Digit serializer: holds one finished BCD word and sends its digits MSD first.
`default_nettype none
module b2ad_emitter (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             up_valid,
  output logic                                  up_ready,
  input  wire logic [b2ad_pkg::BCD_W-1:0]       up_bcd,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [b2ad_pkg::CHAR_W-1:0]           out_char,
  output logic                                  out_last,
  output logic [b2ad_pkg::COUNT_W-1:0]          out_count
);
  logic                           busy_r;
  logic [b2ad_pkg::BCD_W-1:0]     bcd_r;
  logic [b2ad_pkg::IDX_W-1:0]     idx_r;
  logic [b2ad_pkg::COUNT_W-1:0]   count_r;
  logic [b2ad_pkg::COUNT_W-1:0]   count_nxt;
  logic                           fire;
  logic                           load;

  assign out_valid = busy_r;
  assign out_last  = (idx_r == '0);
  assign out_count = count_r;
  assign out_char  = b2ad_pkg::ASCII_ZERO
                   + b2ad_pkg::CHAR_W'(bcd_r[{idx_r, 2'b00} +: 4]);
  assign fire      = out_valid && out_ready;
  assign up_ready  = !busy_r || (fire && out_last);
  assign load      = up_valid && up_ready;

  // Digit count: highest nonzero digit, at least one digit
  always_comb begin
    count_nxt = b2ad_pkg::COUNT_W'(1);
    for (int i = 1; i < b2ad_pkg::NUM_DIGITS; i++) begin
      if (up_bcd[4*i +: 4] != 4'd0) begin
        count_nxt = b2ad_pkg::COUNT_W'(i + 1);
      end
    end
  end

  // Busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (up_ready) begin
      busy_r <= up_valid;
    end
  end

  // Word, count and digit index
  always_ff @(posedge clk) begin
    if (load) begin
      bcd_r   <= up_bcd;
      count_r <= count_nxt;
      idx_r   <= b2ad_pkg::IDX_W'(count_nxt - b2ad_pkg::COUNT_W'(1));
    end else if (fire) begin
      idx_r   <= idx_r - b2ad_pkg::IDX_W'(1);
    end
  end
endmodule
`default_nettype wire
